@@ rtl/core/matrix3x3_inverse_macros.svh @@
// assertion macros for the matrix3x3_inverse checker
`ifndef MATRIX3X3_INVERSE_MACROS_SVH
`define MATRIX3X3_INVERSE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define M3I_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("m3i check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define M3I_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("m3i check failed");

`endif

@@ rtl/core/m3i_pkg.sv @@
// shared constants, types and saturation helper for the 3x3 inverse
package m3i_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned NUM_ELEM = 9;
  localparam int unsigned IDX_W    = $clog2(NUM_ELEM);
  localparam int unsigned PROD_W   = 2 * DATA_W;
  localparam int unsigned COF_W    = PROD_W + 1;
  localparam int unsigned PART_W   = 2 * DATA_W + 1;
  localparam int unsigned DET_W    = 3 * DATA_W + 1;
  localparam int unsigned DMAG_W   = 3 * DATA_W;
  localparam int unsigned NUM_W    = PROD_W + 2 * FRAC_W;
  localparam int unsigned CMP_W    = 4 * DATA_W + 1;
  localparam int unsigned FRONT_ST = 6;
  localparam int unsigned DIV_ST   = DATA_W;
  localparam int unsigned NUM_ST   = FRONT_ST + DIV_ST + 1;

  // element indexes of the two products of each cofactor: a*b - c*d
  localparam logic [IDX_W-1:0] COF_IDX [NUM_ELEM][4] = '{
    '{IDX_W'(4), IDX_W'(8), IDX_W'(5), IDX_W'(7)},
    '{IDX_W'(2), IDX_W'(7), IDX_W'(1), IDX_W'(8)},
    '{IDX_W'(1), IDX_W'(5), IDX_W'(4), IDX_W'(2)},
    '{IDX_W'(6), IDX_W'(5), IDX_W'(3), IDX_W'(8)},
    '{IDX_W'(0), IDX_W'(8), IDX_W'(6), IDX_W'(2)},
    '{IDX_W'(3), IDX_W'(2), IDX_W'(0), IDX_W'(5)},
    '{IDX_W'(3), IDX_W'(7), IDX_W'(6), IDX_W'(4)},
    '{IDX_W'(6), IDX_W'(1), IDX_W'(0), IDX_W'(7)},
    '{IDX_W'(0), IDX_W'(4), IDX_W'(1), IDX_W'(3)}
  };

  typedef logic signed [DATA_W-1:0] elem_t;

  // values shared by all lanes of one transaction
  typedef struct packed {
    logic [DMAG_W-1:0] dmag;
    logic              dneg;
    logic              sing;
    logic [DATA_W-1:0] det_out;
  } ctrl_t;

  // magnitude with sign to saturated two's complement; top bit set means overflow
  function automatic elem_t sat_quo(logic [DATA_W-1:0] mag, logic neg);
    elem_t res;
    if (mag[DATA_W-1]) begin
      res = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else if (neg) begin
      res = -mag;
    end else begin
      res = mag;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/m3i_front.sv @@
// cofactor and determinant pipeline feeding the divider lanes
module m3i_front (
  input  logic                                                   clk_i,
  input  logic [m3i_pkg::FRONT_ST-1:0]                           en_i,
  input  m3i_pkg::elem_t [m3i_pkg::NUM_ELEM-1:0]                 elem_i,
  output logic [m3i_pkg::NUM_ELEM-1:0][m3i_pkg::NUM_W-1:0]       num_o,
  output logic [m3i_pkg::NUM_ELEM-1:0]                           cneg_o,
  output m3i_pkg::ctrl_t                                         ctrl_o
);

  logic signed [m3i_pkg::PROD_W-1:0] pa_q [m3i_pkg::NUM_ELEM];
  logic signed [m3i_pkg::PROD_W-1:0] pb_q [m3i_pkg::NUM_ELEM];
  logic signed [m3i_pkg::COF_W-1:0]  cof2_q [m3i_pkg::NUM_ELEM];
  logic signed [m3i_pkg::COF_W-1:0]  cof3_q [m3i_pkg::NUM_ELEM];
  logic signed [m3i_pkg::COF_W-1:0]  cof4_q [m3i_pkg::NUM_ELEM];
  logic signed [m3i_pkg::COF_W-1:0]  cof5_q [m3i_pkg::NUM_ELEM];
  m3i_pkg::elem_t                    row1_q [3];
  m3i_pkg::elem_t                    row2_q [3];
  logic signed [m3i_pkg::PART_W-1:0] lo_q [3];
  logic signed [m3i_pkg::PART_W-1:0] hi_q [3];
  logic signed [m3i_pkg::DET_W-1:0]  term_q [3];
  logic signed [m3i_pkg::DET_W-1:0]  det_q;

  logic [m3i_pkg::NUM_ELEM-1:0][m3i_pkg::NUM_W-1:0] num_d;
  logic [m3i_pkg::NUM_ELEM-1:0]                     cneg_d;
  logic signed [m3i_pkg::COF_W-1:0]                 cabs [m3i_pkg::NUM_ELEM];
  logic signed [m3i_pkg::DET_W-1:0]                 det_abs;
  logic [m3i_pkg::DMAG_W-1:0]                       mag_sh;
  logic                                             det_big;
  m3i_pkg::ctrl_t                                   ctrl_d;
  m3i_pkg::ctrl_t                                   ctrl_q;
  logic [m3i_pkg::NUM_ELEM-1:0][m3i_pkg::NUM_W-1:0] num_q;
  logic [m3i_pkg::NUM_ELEM-1:0]                     cneg_q;

  // stage 1: the eighteen element products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int k = 0; k < m3i_pkg::NUM_ELEM; k++) begin
        pa_q[k] <= $signed(elem_i[m3i_pkg::COF_IDX[k][0]])
                 * $signed(elem_i[m3i_pkg::COF_IDX[k][1]]);
        pb_q[k] <= $signed(elem_i[m3i_pkg::COF_IDX[k][2]])
                 * $signed(elem_i[m3i_pkg::COF_IDX[k][3]]);
      end
      for (int t = 0; t < 3; t++) begin
        row1_q[t] <= elem_i[t];
      end
    end
  end

  // stage 2: cofactors
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int k = 0; k < m3i_pkg::NUM_ELEM; k++) begin
        cof2_q[k] <= m3i_pkg::COF_W'(pa_q[k]) - m3i_pkg::COF_W'(pb_q[k]);
      end
      row2_q <= row1_q;
    end
  end

  // stage 3: row 0 times cofactor, cofactor split into low and high halves
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int t = 0; t < 3; t++) begin
        lo_q[t] <= row2_q[t] * $signed({1'b0, cof2_q[3*t][m3i_pkg::DATA_W-1:0]});
        hi_q[t] <= row2_q[t]
                 * $signed(cof2_q[3*t][m3i_pkg::COF_W-1:m3i_pkg::DATA_W]);
      end
      cof3_q <= cof2_q;
    end
  end

  // stage 4: recombine the halves of each term
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      for (int t = 0; t < 3; t++) begin
        term_q[t] <= (m3i_pkg::DET_W'(hi_q[t]) <<< m3i_pkg::DATA_W)
                   + m3i_pkg::DET_W'(lo_q[t]);
      end
      cof4_q <= cof3_q;
    end
  end

  // stage 5: exact determinant
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      det_q  <= term_q[0] + term_q[1] + term_q[2];
      cof5_q <= cof4_q;
    end
  end

  // stage 6 logic: magnitudes, shifted numerators, determinant output
  always_comb begin
    for (int k = 0; k < m3i_pkg::NUM_ELEM; k++) begin
      cabs[k]   = cof5_q[k][m3i_pkg::COF_W-1] ? -cof5_q[k] : cof5_q[k];
      num_d[k]  = {cabs[k][m3i_pkg::PROD_W-1:0], {(2*m3i_pkg::FRAC_W){1'b0}}};
      cneg_d[k] = cof5_q[k][m3i_pkg::COF_W-1];
    end
    det_abs      = det_q[m3i_pkg::DET_W-1] ? -det_q : det_q;
    ctrl_d.dmag  = det_abs[m3i_pkg::DMAG_W-1:0];
    ctrl_d.dneg  = det_q[m3i_pkg::DET_W-1];
    ctrl_d.sing  = (det_q == '0);
    mag_sh       = ctrl_d.dmag >> (2 * m3i_pkg::FRAC_W);
    det_big      = (mag_sh[m3i_pkg::DMAG_W-1:m3i_pkg::DATA_W-1] != '0);
    ctrl_d.det_out = m3i_pkg::sat_quo(
      det_big ? {1'b1, {(m3i_pkg::DATA_W-1){1'b0}}} : mag_sh[m3i_pkg::DATA_W-1:0],
      ctrl_d.dneg);
  end

  // stage 6 register
  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      num_q  <= num_d;
      cneg_q <= cneg_d;
      ctrl_q <= ctrl_d;
    end
  end

  assign num_o  = num_q;
  assign cneg_o = cneg_q;
  assign ctrl_o = ctrl_q;

endmodule

@@ rtl/core/m3i_div_lane.sv @@
// one divider lane: restoring division, one quotient bit per stage
module m3i_div_lane (
  input  logic                                                   clk_i,
  input  logic [m3i_pkg::DIV_ST-1:0]                             en_i,
  input  logic [m3i_pkg::NUM_W-1:0]                              num_i,
  input  logic                                                   cneg_i,
  input  logic [m3i_pkg::DIV_ST-1:0][m3i_pkg::DMAG_W-1:0]        dmag_i,
  output logic [m3i_pkg::DATA_W-1:0]                             quo_o,
  output logic                                                   neg_o
);

  logic [m3i_pkg::NUM_W-1:0]  rem_q [m3i_pkg::DIV_ST-1];
  logic [m3i_pkg::DATA_W-1:0] quo_q [m3i_pkg::DIV_ST];
  logic                       neg_q [m3i_pkg::DIV_ST];

  for (genvar s = 0; s < m3i_pkg::DIV_ST; s++) begin : g_step
    localparam int unsigned BIT = m3i_pkg::DIV_ST - 1 - s;
    logic [m3i_pkg::NUM_W-1:0]  rem_in;
    logic [m3i_pkg::DATA_W-1:0] quo_in;
    logic                       neg_in;
    logic [m3i_pkg::CMP_W-1:0]  diff;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
      assign neg_in = cneg_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign neg_in = neg_q[s-1];
    end

    // trial subtract of the shifted divisor
    assign diff = m3i_pkg::CMP_W'(rem_in) - (m3i_pkg::CMP_W'(dmag_i[s]) << BIT);

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        neg_q[s] <= neg_in;
        if (!diff[m3i_pkg::CMP_W-1]) begin
          quo_q[s] <= quo_in | (m3i_pkg::DATA_W'(1) << BIT);
        end else begin
          quo_q[s] <= quo_in;
        end
      end
    end

    // last step needs no remainder
    if (s < m3i_pkg::DIV_ST - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          rem_q[s] <= diff[m3i_pkg::CMP_W-1] ? rem_in : diff[m3i_pkg::NUM_W-1:0];
        end
      end
    end
  end

  assign quo_o = quo_q[m3i_pkg::DIV_ST-1];
  assign neg_o = neg_q[m3i_pkg::DIV_ST-1];

endmodule

@@ rtl/core/matrix3x3_inverse.sv @@
// 3x3 fixed-point matrix inverse by adjugate over nine parallel divider lanes
// pipeline order: cofactor and determinant front, divider stages, output merge register
// one matrix per cycle unless stalled; each stage moves alone, so bubbles close up
// the divide takes 32 stages, one quotient bit per stage in each of the nine lanes
// reset clears the stage valid bits only; payload registers are not reset
module matrix3x3_inverse (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  m3i_pkg::elem_t               m00_i,
  input  m3i_pkg::elem_t               m01_i,
  input  m3i_pkg::elem_t               m02_i,
  input  m3i_pkg::elem_t               m10_i,
  input  m3i_pkg::elem_t               m11_i,
  input  m3i_pkg::elem_t               m12_i,
  input  m3i_pkg::elem_t               m20_i,
  input  m3i_pkg::elem_t               m21_i,
  input  m3i_pkg::elem_t               m22_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output m3i_pkg::elem_t               r00_o,
  output m3i_pkg::elem_t               r01_o,
  output m3i_pkg::elem_t               r02_o,
  output m3i_pkg::elem_t               r10_o,
  output m3i_pkg::elem_t               r11_o,
  output m3i_pkg::elem_t               r12_o,
  output m3i_pkg::elem_t               r20_o,
  output m3i_pkg::elem_t               r21_o,
  output m3i_pkg::elem_t               r22_o,
  output m3i_pkg::elem_t               determinant_o,
  output logic                         singular_o
);

  m3i_pkg::elem_t [m3i_pkg::NUM_ELEM-1:0]                elem;
  logic [m3i_pkg::NUM_ST-1:0]                            vld_q;
  logic [m3i_pkg::NUM_ST-1:0]                            vld_d;
  logic [m3i_pkg::NUM_ST:0]                              rdy;
  logic [m3i_pkg::NUM_ELEM-1:0][m3i_pkg::NUM_W-1:0]      num;
  logic [m3i_pkg::NUM_ELEM-1:0]                          cneg;
  m3i_pkg::ctrl_t                                        front_ctrl;
  m3i_pkg::ctrl_t                                        ctl_q [m3i_pkg::DIV_ST];
  logic [m3i_pkg::DIV_ST-1:0][m3i_pkg::DMAG_W-1:0]       div_dmag;
  logic [m3i_pkg::DATA_W-1:0]                            quo [m3i_pkg::NUM_ELEM];
  logic [m3i_pkg::NUM_ELEM-1:0]                          qneg;
  m3i_pkg::elem_t                                        res_q [m3i_pkg::NUM_ELEM];
  m3i_pkg::elem_t                                        det_q;
  logic                                                  sing_q;

  assign elem = {m22_i, m21_i, m20_i, m12_i, m11_i, m10_i, m02_i, m01_i, m00_i};

  // per-stage ready: a stage loads when it is empty or its successor moves
  assign rdy[m3i_pkg::NUM_ST] = !out_stall_i;
  for (genvar k = 0; k < m3i_pkg::NUM_ST; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  assign vld_d = {vld_q[m3i_pkg::NUM_ST-2:0], in_valid_i};

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (rdy[m3i_pkg::NUM_ST-1:0] & vld_d) | (~rdy[m3i_pkg::NUM_ST-1:0] & vld_q);
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[m3i_pkg::NUM_ST-1];

  // cofactors and determinant
  m3i_front u_front (
    .clk_i  (clk_i),
    .en_i   (rdy[m3i_pkg::FRONT_ST-1:0]),
    .elem_i (elem),
    .num_o  (num),
    .cneg_o (cneg),
    .ctrl_o (front_ctrl)
  );

  // shared divisor and flags travel beside the lanes
  for (genvar s = 0; s < m3i_pkg::DIV_ST; s++) begin : g_ctl
    if (s == 0) begin : g_first
      assign div_dmag[s] = front_ctrl.dmag;
      always_ff @(posedge clk_i) begin
        if (rdy[m3i_pkg::FRONT_ST]) begin
          ctl_q[s] <= front_ctrl;
        end
      end
    end else begin : g_next
      assign div_dmag[s] = ctl_q[s-1].dmag;
      always_ff @(posedge clk_i) begin
        if (rdy[m3i_pkg::FRONT_ST+s]) begin
          ctl_q[s] <= ctl_q[s-1];
        end
      end
    end
  end

  // nine divider lanes
  for (genvar k = 0; k < m3i_pkg::NUM_ELEM; k++) begin : g_lane
    m3i_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (rdy[m3i_pkg::FRONT_ST +: m3i_pkg::DIV_ST]),
      .num_i  (num[k]),
      .cneg_i (cneg[k]),
      .dmag_i (div_dmag),
      .quo_o  (quo[k]),
      .neg_o  (qneg[k])
    );
  end

  // merge stage: sign, saturation and singular zeroing into the output register
  always_ff @(posedge clk_i) begin
    if (rdy[m3i_pkg::NUM_ST-1]) begin
      for (int k = 0; k < m3i_pkg::NUM_ELEM; k++) begin
        res_q[k] <= ctl_q[m3i_pkg::DIV_ST-1].sing ? '0
                  : m3i_pkg::sat_quo(quo[k], qneg[k] ^ ctl_q[m3i_pkg::DIV_ST-1].dneg);
      end
      det_q  <= ctl_q[m3i_pkg::DIV_ST-1].det_out;
      sing_q <= ctl_q[m3i_pkg::DIV_ST-1].sing;
    end
  end

  assign r00_o         = res_q[0];
  assign r01_o         = res_q[1];
  assign r02_o         = res_q[2];
  assign r10_o         = res_q[3];
  assign r11_o         = res_q[4];
  assign r12_o         = res_q[5];
  assign r20_o         = res_q[6];
  assign r21_o         = res_q[7];
  assign r22_o         = res_q[8];
  assign determinant_o = det_q;
  assign singular_o    = sing_q;

endmodule

@@ rtl/core/m3i_checker.sv @@
// port-level checker for matrix3x3_inverse and its bind
`include "matrix3x3_inverse_macros.svh"

module m3i_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input m3i_pkg::elem_t m00_i,
  input m3i_pkg::elem_t m01_i,
  input m3i_pkg::elem_t m02_i,
  input m3i_pkg::elem_t m10_i,
  input m3i_pkg::elem_t m11_i,
  input m3i_pkg::elem_t m12_i,
  input m3i_pkg::elem_t m20_i,
  input m3i_pkg::elem_t m21_i,
  input m3i_pkg::elem_t m22_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input m3i_pkg::elem_t r00_o,
  input m3i_pkg::elem_t r01_o,
  input m3i_pkg::elem_t r02_o,
  input m3i_pkg::elem_t r10_o,
  input m3i_pkg::elem_t r11_o,
  input m3i_pkg::elem_t r12_o,
  input m3i_pkg::elem_t r20_o,
  input m3i_pkg::elem_t r21_o,
  input m3i_pkg::elem_t r22_o,
  input m3i_pkg::elem_t determinant_o,
  input logic           singular_o
);

  logic                          res_zero;
  logic [10*m3i_pkg::DATA_W:0]   out_word;

  // all result fields zero
  assign res_zero = (r00_o == '0) && (r01_o == '0) && (r02_o == '0) && (r10_o == '0)
                 && (r11_o == '0) && (r12_o == '0) && (r20_o == '0) && (r21_o == '0)
                 && (r22_o == '0) && (determinant_o == '0);

  assign out_word = {r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o,
                     determinant_o, singular_o};

  // a singular matrix gives an all-zero result
  `M3I_ASSERT_IMP(a_sing_zero, out_valid_o && singular_o, res_zero)

  // the input side backs up only behind a held result
  `M3I_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // a held result stays valid
  `M3I_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // a held result does not change
  `M3I_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_word))

endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (.*);
